// ===== sv/bqbc_pkg.sv =====
// ----------------------------------------------------------------------------
// bqbc_pkg
// Symbol codes, verdict codes and character constants for the bracket and
// quote balance checker.
// ----------------------------------------------------------------------------
package bqbc_pkg;

    localparam int STACK_DEPTH_DEFAULT = 64;

    typedef logic [2:0] sym_t;
    typedef logic [2:0] verdict_t;
    typedef logic [7:0] char_t;

    localparam sym_t SYM_NONE   = 3'd0;
    localparam sym_t SYM_PAREN  = 3'd1;
    localparam sym_t SYM_SQUARE = 3'd2;
    localparam sym_t SYM_CURLY  = 3'd3;
    localparam sym_t SYM_SQUOTE = 3'd4;
    localparam sym_t SYM_DQUOTE = 3'd5;

    localparam verdict_t V_OK           = 3'd0;
    localparam verdict_t V_MISMATCH     = 3'd1;
    localparam verdict_t V_UNCLOSED     = 3'd2;
    localparam verdict_t V_UNRECOGNIZED = 3'd3;
    localparam verdict_t V_OVERFLOW     = 3'd4;

    localparam char_t CH_NUL     = 8'd0;
    localparam char_t CH_ASCII_HI = 8'd128;
    localparam char_t CH_LPAREN  = 8'h28;
    localparam char_t CH_RPAREN  = 8'h29;
    localparam char_t CH_LSQUARE = 8'h5B;
    localparam char_t CH_RSQUARE = 8'h5D;
    localparam char_t CH_LCURLY  = 8'h7B;
    localparam char_t CH_RCURLY  = 8'h7D;
    localparam char_t CH_SQUOTE  = 8'd39;
    localparam char_t CH_DQUOTE  = 8'd34;

endpackage

// ===== sv/bracket_quote_balance_checker.sv =====
// Output: the verdict for a string is registered and shows in the cycle after
//   its last beat is accepted; beats without the last flag give no result.
// Throughput: one beat per cycle while in_stall is low; each beat needs one
//   top-of-stack compare, with the entry below prefetched from stack memory.
// Reset: rst_n clears level, error, top and output valid; stack memory is not
//   cleared, since only entries below the level are ever used.
// ----------------------------------------------------------------------------
// bracket_quote_balance_checker
// Byte-stream checker for balanced brackets and quotes. Keeps each stack entry
// in a memory and the top also in a register; gives one verdict per string.
// ----------------------------------------------------------------------------
module bracket_quote_balance_checker #(
    parameter int STACK_DEPTH = bqbc_pkg::STACK_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          char_code,
    input  logic                last,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [2:0]          verdict
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int LW = $clog2(STACK_DEPTH + 1);

    bqbc_pkg::sym_t     stack_mem [STACK_DEPTH];

    logic [LW-1:0]      level_reg, level_next;
    bqbc_pkg::verdict_t err_reg, err_next;
    bqbc_pkg::sym_t     top_reg, top_next;
    bqbc_pkg::sym_t     below_reg;      // always stack_mem[level_reg - 2]
    logic               out_valid_reg, out_valid_next;
    bqbc_pkg::verdict_t verdict_reg, verdict_next;

    logic               in_accept;
    logic               out_accept;
    logic               do_push;
    logic               do_close;
    logic               do_pop;
    bqbc_pkg::sym_t     op_sym;
    logic               mem_we;
    logic [AW-1:0]      below_addr;
    bqbc_pkg::verdict_t err_exam;
    logic [LW-1:0]      level_exam;

    assign out_accept = out_valid_reg && !out_stall;
    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign verdict    = verdict_reg;

    // decode the beat into a push, a close or a quote toggle
    always_comb
    begin
        do_push  = 1'b0;
        do_close = 1'b0;
        op_sym   = bqbc_pkg::SYM_NONE;
        case (char_code)
            bqbc_pkg::CH_LPAREN:
            begin
                do_push = 1'b1;
                op_sym  = bqbc_pkg::SYM_PAREN;
            end
            bqbc_pkg::CH_LSQUARE:
            begin
                do_push = 1'b1;
                op_sym  = bqbc_pkg::SYM_SQUARE;
            end
            bqbc_pkg::CH_LCURLY:
            begin
                do_push = 1'b1;
                op_sym  = bqbc_pkg::SYM_CURLY;
            end
            bqbc_pkg::CH_RPAREN:
            begin
                do_close = 1'b1;
                op_sym   = bqbc_pkg::SYM_PAREN;
            end
            bqbc_pkg::CH_RSQUARE:
            begin
                do_close = 1'b1;
                op_sym   = bqbc_pkg::SYM_SQUARE;
            end
            bqbc_pkg::CH_RCURLY:
            begin
                do_close = 1'b1;
                op_sym   = bqbc_pkg::SYM_CURLY;
            end
            bqbc_pkg::CH_SQUOTE:
            begin
                op_sym = bqbc_pkg::SYM_SQUOTE;
                if (level_reg != '0 && top_reg == bqbc_pkg::SYM_SQUOTE)
                    do_close = 1'b1;
                else
                    do_push = 1'b1;
            end
            bqbc_pkg::CH_DQUOTE:
            begin
                op_sym = bqbc_pkg::SYM_DQUOTE;
                if (level_reg != '0 && top_reg == bqbc_pkg::SYM_DQUOTE)
                    do_close = 1'b1;
                else
                    do_push = 1'b1;
            end
            default:
            begin
                do_push  = 1'b0;
                do_close = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        err_exam   = err_reg;
        level_exam = level_reg;
        top_next   = top_reg;
        mem_we     = 1'b0;
        do_pop     = 1'b0;

        if (in_accept && err_reg == bqbc_pkg::V_OK)
        begin
            if (char_code == bqbc_pkg::CH_NUL || char_code >= bqbc_pkg::CH_ASCII_HI)
                err_exam = bqbc_pkg::V_UNRECOGNIZED;
            else if (do_push)
            begin
                if (level_reg >= LW'(STACK_DEPTH))
                    err_exam = bqbc_pkg::V_OVERFLOW;
                else
                begin
                    mem_we     = 1'b1;
                    top_next   = op_sym;
                    level_exam = level_reg + LW'(1);
                end
            end
            else if (do_close)
            begin
                if (level_reg == '0 || top_reg != op_sym)
                    err_exam = bqbc_pkg::V_MISMATCH;
                else
                begin
                    do_pop     = 1'b1;
                    top_next   = below_reg;
                    level_exam = level_reg - LW'(1);
                end
            end
        end

        err_next     = err_exam;
        level_next   = level_exam;
        verdict_next = verdict_reg;
        if (in_accept && last)
        begin
            if (err_exam != bqbc_pkg::V_OK)
                verdict_next = err_exam;
            else if (level_exam != '0)
                verdict_next = bqbc_pkg::V_UNCLOSED;
            else
                verdict_next = bqbc_pkg::V_OK;
            err_next   = bqbc_pkg::V_OK;
            level_next = '0;
        end

        if (in_accept && last)
            out_valid_next = 1'b1;
        else if (out_accept)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // prefetch the entry under the new top; except on a last beat, whose
    // prefetch is unused, it never collides with the write at the old level
    assign below_addr = AW'(level_next - LW'(2));

    always_ff @(posedge clk)
    begin
        if (mem_we)
            stack_mem[level_reg[AW-1:0]] <= op_sym;
        below_reg <= stack_mem[below_addr];
    end

    always_ff @(posedge clk)
    begin
        verdict_reg <= verdict_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            err_reg       <= bqbc_pkg::V_OK;
            top_reg       <= bqbc_pkg::SYM_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg     <= level_next;
            err_reg       <= err_next;
            top_reg       <= (do_pop || mem_we) ? top_next : top_reg;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== test/tb_bracket_quote_balance_checker.sv =====
// ----------------------------------------------------------------------------
// tb_bracket_quote_balance_checker
// Streams byte strings into the bracket and quote balance checker and checks
// every verdict against a cycle-free model of the symbol stack. Directed
// strings cover each symbol, bad bytes, closers on an empty stack and sticky
// errors. Random strings are mostly nested brackets and quotes with filler,
// some corrupted, some deep enough to overflow the stack, plus raw noise.
// Both sides idle and stall at different rates across the run.
// ----------------------------------------------------------------------------
module tb_bracket_quote_balance_checker;

    localparam int DEPTH = bqbc_pkg::STACK_DEPTH_DEFAULT;

    typedef struct packed {
        bqbc_pkg::char_t code;
        logic            is_last;
    } beat_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] char_code = 8'd0;
    logic       last      = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [2:0] verdict;

    beat_t              beats_to_send[$];
    bqbc_pkg::verdict_t verdicts_due[$];

    // model state
    bqbc_pkg::sym_t     model_stack [DEPTH];
    int                 model_level = 0;
    bqbc_pkg::verdict_t model_error = bqbc_pkg::V_OK;

    int mismatches    = 0;
    int verdicts_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;

    bracket_quote_balance_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .verdict   (verdict)
    );

    always #4 clk = ~clk;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic push_sym(input bqbc_pkg::sym_t s);
        if (model_level >= DEPTH)
            model_error = bqbc_pkg::V_OVERFLOW;
        else
        begin
            model_stack[model_level] = s;
            model_level++;
        end
    endtask

    task automatic close_sym(input bqbc_pkg::sym_t s);
        if (model_level == 0 || model_stack[model_level - 1] != s)
            model_error = bqbc_pkg::V_MISMATCH;
        else
            model_level--;
    endtask

    task automatic quote_sym(input bqbc_pkg::sym_t s);
        if (model_level != 0 && model_stack[model_level - 1] == s)
            model_level--;
        else
            push_sym(s);
    endtask

    // Applies one accepted beat; queues a verdict on the last beat of a string.
    task automatic absorb_beat(input bqbc_pkg::char_t c, input logic is_last);
        bqbc_pkg::verdict_t v;
        if (model_error == bqbc_pkg::V_OK)
        begin
            if (c == bqbc_pkg::CH_NUL || c >= bqbc_pkg::CH_ASCII_HI)
                model_error = bqbc_pkg::V_UNRECOGNIZED;
            else
                case (c)
                    bqbc_pkg::CH_LPAREN:  push_sym(bqbc_pkg::SYM_PAREN);
                    bqbc_pkg::CH_LSQUARE: push_sym(bqbc_pkg::SYM_SQUARE);
                    bqbc_pkg::CH_LCURLY:  push_sym(bqbc_pkg::SYM_CURLY);
                    bqbc_pkg::CH_RPAREN:  close_sym(bqbc_pkg::SYM_PAREN);
                    bqbc_pkg::CH_RSQUARE: close_sym(bqbc_pkg::SYM_SQUARE);
                    bqbc_pkg::CH_RCURLY:  close_sym(bqbc_pkg::SYM_CURLY);
                    bqbc_pkg::CH_SQUOTE:  quote_sym(bqbc_pkg::SYM_SQUOTE);
                    bqbc_pkg::CH_DQUOTE:  quote_sym(bqbc_pkg::SYM_DQUOTE);
                    default: ;
                endcase
        end
        if (is_last)
        begin
            if (model_error != bqbc_pkg::V_OK)
                v = model_error;
            else if (model_level != 0)
                v = bqbc_pkg::V_UNCLOSED;
            else
                v = bqbc_pkg::V_OK;
            verdicts_due.push_back(v);
            model_level = 0;
            model_error = bqbc_pkg::V_OK;
        end
    endtask

    function automatic bqbc_pkg::char_t opener_char(input bqbc_pkg::sym_t s);
        case (s)
            bqbc_pkg::SYM_PAREN:  return bqbc_pkg::CH_LPAREN;
            bqbc_pkg::SYM_SQUARE: return bqbc_pkg::CH_LSQUARE;
            bqbc_pkg::SYM_CURLY:  return bqbc_pkg::CH_LCURLY;
            bqbc_pkg::SYM_SQUOTE: return bqbc_pkg::CH_SQUOTE;
            default:              return bqbc_pkg::CH_DQUOTE;
        endcase
    endfunction

    function automatic bqbc_pkg::char_t closer_char(input bqbc_pkg::sym_t s);
        case (s)
            bqbc_pkg::SYM_PAREN:  return bqbc_pkg::CH_RPAREN;
            bqbc_pkg::SYM_SQUARE: return bqbc_pkg::CH_RSQUARE;
            bqbc_pkg::SYM_CURLY:  return bqbc_pkg::CH_RCURLY;
            bqbc_pkg::SYM_SQUOTE: return bqbc_pkg::CH_SQUOTE;
            default:              return bqbc_pkg::CH_DQUOTE;
        endcase
    endfunction

    // any byte the checker passes over: 1..127 minus brackets and quotes
    function automatic bqbc_pkg::char_t filler_char();
        bqbc_pkg::char_t c;
        do
            c = bqbc_pkg::char_t'($urandom_range(1, 127));
        while (c == bqbc_pkg::CH_LPAREN || c == bqbc_pkg::CH_RPAREN ||
               c == bqbc_pkg::CH_LSQUARE || c == bqbc_pkg::CH_RSQUARE ||
               c == bqbc_pkg::CH_LCURLY || c == bqbc_pkg::CH_RCURLY ||
               c == bqbc_pkg::CH_SQUOTE || c == bqbc_pkg::CH_DQUOTE);
        return c;
    endfunction

    task automatic queue_string(input bqbc_pkg::char_t s[$]);
        beat_t b;
        foreach (s[i])
        begin
            b.code    = s[i];
            b.is_last = (i == s.size() - 1);
            beats_to_send.push_back(b);
        end
    endtask

    // Builds one random string and queues it; returns its length in beats.
    task automatic queue_random_string(output int n);
        bqbc_pkg::char_t s[$];
        bqbc_pkg::sym_t  open_syms[$];
        bqbc_pkg::sym_t  sy;
        int              r;
        int              len;
        int              max_nest;
        r = $urandom_range(99);
        if (r < 2)
        begin
            // deep nesting around the stack limit
            len = $urandom_range(DEPTH - 1, DEPTH + 2);
            repeat (len)
            begin
                sy = bqbc_pkg::sym_t'($urandom_range(bqbc_pkg::SYM_PAREN,
                                                     bqbc_pkg::SYM_CURLY));
                open_syms.push_back(sy);
                s.push_back(opener_char(sy));
            end
            while (open_syms.size() != 0)
                s.push_back(closer_char(open_syms.pop_back()));
        end
        else if (r < 12)
        begin
            repeat ($urandom_range(1, 8))
                s.push_back(bqbc_pkg::char_t'($urandom_range(0, 255)));
        end
        else
        begin
            len      = $urandom_range(1, 20);
            max_nest = $urandom_range(1, 8);
            repeat (len)
            begin
                r = $urandom_range(2);
                if (r == 0 && open_syms.size() < max_nest)
                begin
                    sy = bqbc_pkg::sym_t'($urandom_range(bqbc_pkg::SYM_PAREN,
                                                         bqbc_pkg::SYM_DQUOTE));
                    // a quote on top of the same quote closes it
                    if (open_syms.size() != 0 && open_syms[$] == sy &&
                        (sy == bqbc_pkg::SYM_SQUOTE || sy == bqbc_pkg::SYM_DQUOTE))
                        void'(open_syms.pop_back());
                    else
                        open_syms.push_back(sy);
                    s.push_back(opener_char(sy));
                end
                else if (r == 1 && open_syms.size() != 0)
                    s.push_back(closer_char(open_syms.pop_back()));
                else
                    s.push_back(filler_char());
            end
            while (open_syms.size() != 0)
                s.push_back(closer_char(open_syms.pop_back()));
            if ($urandom_range(3) == 0)
                case ($urandom_range(2))
                    0: s[$urandom_range(s.size() - 1)] =
                           bqbc_pkg::char_t'($urandom_range(0, 255));
                    1: if (s.size() > 1) void'(s.pop_back());
                    default: s.push_back(closer_char(bqbc_pkg::sym_t'(
                                 $urandom_range(bqbc_pkg::SYM_PAREN,
                                                bqbc_pkg::SYM_CURLY))));
                endcase
        end
        queue_string(s);
        n = s.size();
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin : sender
        beat_t b;
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            char_code <= 8'd0;
            last      <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
                absorb_beat(char_code, last);
            if (!in_valid || !in_stall)
            begin
                if (beats_to_send.size() != 0 &&
                    !(send_idle_pct != 0 && $urandom_range(99) < send_idle_pct))
                begin
                    b = beats_to_send.pop_front();
                    char_code <= b.code;
                    last      <= b.is_last;
                    in_valid  <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off early in the run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && verdicts_seen >= 12)
        begin
            hold_done <= 1'b1;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // monitor
    always @(posedge clk)
    begin : monitor
        bqbc_pkg::verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdicts_due.size() == 0)
                report_mismatch($sformatf("verdict %0d with none expected", verdict));
            else
            begin
                want = verdicts_due.pop_front();
                if (verdict !== want)
                    report_mismatch($sformatf("verdict %0d, expected %0d", verdict, want));
            end
            verdicts_seen <= verdicts_seen + 1;
        end
    end

    initial
    begin : stimulus
        bqbc_pkg::char_t s[$];
        int              n;
        int              phase_beats;
        for (int i = 0; i < DEPTH; i++)
            model_stack[i] = bqbc_pkg::SYM_NONE;

        // directed strings
        s = '{bqbc_pkg::CH_LPAREN, bqbc_pkg::CH_LSQUARE, bqbc_pkg::CH_LCURLY,
              bqbc_pkg::CH_RCURLY, bqbc_pkg::CH_RSQUARE, bqbc_pkg::CH_RPAREN};
        queue_string(s);
        s = '{bqbc_pkg::CH_SQUOTE, bqbc_pkg::CH_DQUOTE, bqbc_pkg::CH_DQUOTE,
              bqbc_pkg::CH_SQUOTE};
        queue_string(s);
        s = '{bqbc_pkg::CH_RPAREN};                       // closer on empty stack
        queue_string(s);
        s = '{bqbc_pkg::CH_LPAREN, bqbc_pkg::CH_RSQUARE};
        queue_string(s);
        s = '{bqbc_pkg::CH_LCURLY};                       // left open at end
        queue_string(s);
        s = '{bqbc_pkg::CH_NUL};
        queue_string(s);
        s = '{8'd255};
        queue_string(s);
        s = '{bqbc_pkg::CH_ASCII_HI};
        queue_string(s);
        s = '{8'h3C, 8'h3E};                              // angle brackets pass through
        queue_string(s);
        s = '{bqbc_pkg::CH_LSQUARE, 8'd127};
        queue_string(s);
        s = '{bqbc_pkg::CH_RCURLY, bqbc_pkg::CH_LPAREN};  // first error sticks
        queue_string(s);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            @(negedge clk);
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            phase_beats = 0;
            while (phase_beats < 310)
            begin
                queue_random_string(n);
                phase_beats += n;
            end
            while (beats_to_send.size() != 0)
                @(negedge clk);
        end

        while (beats_to_send.size() != 0 || in_valid || verdicts_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ===== bracket_quote_balance_checker.f =====
sv/bqbc_pkg.sv
sv/bracket_quote_balance_checker.sv
test/tb_bracket_quote_balance_checker.sv
